// ===== sv/swb_pkg.sv =====
package swb_pkg;

  localparam int unsigned DepthDefault     = 64;
  localparam int unsigned DataWidthDefault = 64;
  localparam int unsigned KeyWidth         = 64;
  localparam int unsigned StatusWidth      = 3;
  localparam int unsigned OccWidth         = 7;

  localparam logic [StatusWidth-1:0] StNew     = 3'd0;
  localparam logic [StatusWidth-1:0] StUpdated = 3'd1;
  localparam logic [StatusWidth-1:0] StDropped = 3'd2;
  localparam logic [StatusWidth-1:0] StFlushed = 3'd3;
  localparam logic [StatusWidth-1:0] StEmpty   = 3'd4;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncFlush  = 1'b1;

endpackage

// ===== sv/swb_front.sv =====
// Front end: input register and a two-entry command queue toward the back end.
module swb_front #(
  parameter int unsigned DataWidth = swb_pkg::DataWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic                         func_i,
  input  logic [swb_pkg::KeyWidth-1:0] key_i,
  input  logic [63:0]                  value_i,
  output logic                         cmd_valid_o,
  input  logic                         cmd_ready_i,
  output logic                         cmd_func_o,
  output logic [swb_pkg::KeyWidth-1:0] cmd_key_o,
  output logic [DataWidth-1:0]         cmd_value_o
);

  logic                         func_q [2];
  logic [swb_pkg::KeyWidth-1:0] key_q [2];
  logic [DataWidth-1:0]         value_q [2];
  logic                         wr_q, rd_q;
  logic [1:0]                   cnt_q;
  logic                         push, pop;

  assign ready_o     = (cnt_q != 2'd2);
  assign push        = valid_i && ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_func_o  = func_q[rd_q];
  assign cmd_key_o   = key_q[rd_q];
  assign cmd_value_o = value_q[rd_q];

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage; the value is cut to the stored width on entry.
  always_ff @(posedge clk_i) begin
    if (push) begin
      func_q[wr_q]  <= func_i;
      key_q[wr_q]   <= key_i;
      value_q[wr_q] <= value_i[DataWidth-1:0];
    end
  end

endmodule

// ===== sv/swb_back.sv =====
// Back end: a row of sorted cells with parallel compare and shift, plus the flush drain.
module swb_back #(
  parameter int unsigned Depth     = swb_pkg::DepthDefault,
  parameter int unsigned DataWidth = swb_pkg::DataWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  output logic                            cmd_ready_o,
  input  logic                            cmd_func_i,
  input  logic [swb_pkg::KeyWidth-1:0]    cmd_key_i,
  input  logic [DataWidth-1:0]            cmd_value_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [swb_pkg::StatusWidth-1:0] status_o,
  output logic [swb_pkg::KeyWidth-1:0]    out_key_o,
  output logic [63:0]                     out_value_o,
  output logic                            last_o,
  output logic [swb_pkg::OccWidth-1:0]    occupancy_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [swb_pkg::KeyWidth-1:0] keys_q [Depth];
  logic [DataWidth-1:0]         vals_q [Depth];
  logic [CntW-1:0]              count_q, count_d;
  logic                         flush_q;

  // Output register.
  logic                            ovalid_q;
  logic [swb_pkg::StatusWidth-1:0] ost_q;
  logic [swb_pkg::KeyWidth-1:0]    okey_q;
  logic [DataWidth-1:0]            oval_q;
  logic                            olast_q;
  logic [swb_pkg::OccWidth-1:0]    oocc_q;

  logic out_free;
  logic take;
  logic flush_start;
  logic [Depth-1:0] occ, ge, eq;
  logic hit, full;

  assign out_free    = !ovalid_q || ready_i;
  assign cmd_ready_o = out_free && !flush_q;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign full        = (count_q == CntW'(Depth));

  // A non-empty flush is announced by its first drained entry only.
  assign flush_start = take && (cmd_func_i == swb_pkg::FuncFlush) && (count_q != '0);

  // Per-cell compare against the incoming key.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      occ[i] = (CntW'(i) < count_q);
      ge[i]  = occ[i] && (keys_q[i] >= cmd_key_i);
      eq[i]  = occ[i] && (keys_q[i] == cmd_key_i);
    end
    hit = |eq;
  end

  assign count_d = count_q + CntW'(1);

  // Cell row: update, shift-insert, or shift-down during a flush.
  always_ff @(posedge clk_i) begin
    if (take && cmd_func_i == swb_pkg::FuncInsert) begin
      if (hit) begin
        for (int i = 0; i < Depth; i++)
          if (eq[i]) vals_q[i] <= cmd_value_i;
      end else if (!full) begin
        if (ge[0] || !occ[0]) begin
          keys_q[0] <= cmd_key_i;
          vals_q[0] <= cmd_value_i;
        end
        for (int i = 1; i < Depth; i++) begin
          if (ge[i] || !occ[i]) begin
            if (!ge[i-1] && occ[i-1]) begin
              keys_q[i] <= cmd_key_i;
              vals_q[i] <= cmd_value_i;
            end else begin
              keys_q[i] <= keys_q[i-1];
              vals_q[i] <= vals_q[i-1];
            end
          end
        end
      end
    end else if (flush_q && out_free) begin
      for (int i = 0; i < Depth - 1; i++) begin
        keys_q[i] <= keys_q[i+1];
        vals_q[i] <= vals_q[i+1];
      end
    end
  end

  // Control and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      flush_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else if (out_free) begin
      ovalid_q <= flush_q || (take && !flush_start);
      if (flush_q) begin
        count_q <= count_q - CntW'(1);
        if (count_q == CntW'(1)) flush_q <= 1'b0;
      end else if (take) begin
        if (flush_start) begin
          flush_q <= 1'b1;
        end else if (cmd_func_i == swb_pkg::FuncInsert && !hit && !full) begin
          count_q <= count_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (flush_q) begin
        ost_q   <= swb_pkg::StFlushed;
        okey_q  <= keys_q[0];
        oval_q  <= vals_q[0];
        olast_q <= (count_q == CntW'(1));
        oocc_q  <= '0;
      end else begin
        okey_q  <= '0;
        oval_q  <= '0;
        olast_q <= 1'b1;
        if (cmd_func_i == swb_pkg::FuncFlush) begin
          ost_q  <= swb_pkg::StEmpty;
          oocc_q <= '0;
        end else if (hit) begin
          ost_q  <= swb_pkg::StUpdated;
          oocc_q <= swb_pkg::OccWidth'(count_q);
        end else if (full) begin
          ost_q  <= swb_pkg::StDropped;
          oocc_q <= swb_pkg::OccWidth'(count_q);
        end else begin
          ost_q  <= swb_pkg::StNew;
          oocc_q <= swb_pkg::OccWidth'(count_d);
        end
      end
    end
  end

  assign valid_o     = ovalid_q;
  assign status_o    = ost_q;
  assign out_key_o   = okey_q;
  assign out_value_o = 64'(oval_q);
  assign last_o      = olast_q;
  assign occupancy_o = oocc_q;

endmodule

// ===== sv/sorted_write_buffer_unit.sv =====
// Sorted key/value buffer. An insert goes through the command queue, then the result
// register; inserts stream at one per cycle while the receiver is ready. A flush of N
// entries gives N results, one per cycle while the receiver is ready; the flush command
// passes the command queue and the flush state before its first entry is registered.
// New commands wait until the last one is out. Reset (asynchronous, active low) empties
// the buffer, command queue and result register; stored keys and values are not cleared.
module sorted_write_buffer_unit #(
  parameter int unsigned DEPTH      = swb_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = swb_pkg::DataWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic                            func_i,
  input  logic [swb_pkg::KeyWidth-1:0]    key_i,
  input  logic [63:0]                     value_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [swb_pkg::StatusWidth-1:0] status_o,
  output logic [swb_pkg::KeyWidth-1:0]    out_key_o,
  output logic [63:0]                     out_value_o,
  output logic                            last_o,
  output logic [swb_pkg::OccWidth-1:0]    occupancy_o
);

  logic                         cmd_valid, cmd_ready, cmd_func;
  logic [swb_pkg::KeyWidth-1:0] cmd_key;
  logic [DATA_WIDTH-1:0]        cmd_value;

  swb_front #(.DataWidth(DATA_WIDTH)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .func_i, .key_i, .value_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_func_o(cmd_func),
    .cmd_key_o(cmd_key), .cmd_value_o(cmd_value)
  );

  swb_back #(.Depth(DEPTH), .DataWidth(DATA_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_func_i(cmd_func),
    .cmd_key_i(cmd_key), .cmd_value_i(cmd_value),
    .valid_o, .ready_i, .status_o, .out_key_o, .out_value_o, .last_o, .occupancy_o
  );

endmodule

// ===== bench/sorted_write_buffer_unit_tb.sv =====
module sorted_write_buffer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = swb_pkg::DepthDefault;
  localparam int unsigned NumRandom = 270;
  localparam longint unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [swb_pkg::StatusWidth-1:0] status;
    logic [swb_pkg::KeyWidth-1:0]    okey;
    logic [63:0]                     oval;
    logic                            last;
    logic [swb_pkg::OccWidth-1:0]    occ;
  } result_t;

  typedef struct {
    logic        func;
    logic [63:0] key;
    logic [63:0] value;
    bit          has_result;
    result_t     result;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic func_i = swb_pkg::FuncInsert;
  logic [63:0] key_i = '0;
  logic [63:0] value_i = '0;
  logic ready_i = 1'b0;
  logic ready_o, valid_o, last_o;
  logic [swb_pkg::StatusWidth-1:0] status_o;
  logic [swb_pkg::KeyWidth-1:0] out_key_o;
  logic [63:0] out_value_o;
  logic [swb_pkg::OccWidth-1:0] occupancy_o;

  // Shadow of the buffer contents, kept in ascending key order.
  logic [63:0] shadow_keys[Depth];
  logic [63:0] shadow_values[Depth];
  int unsigned shadow_count;

  result_t pending_results[$];
  stim_row_t directed_rows[$];
  result_t last_predicted;
  int unsigned predicted_total = 0;
  int unsigned mismatch_count = 0;
  longint unsigned cycle_count = 0;
  bit hold_off = 1'b0;

  sorted_write_buffer_unit u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Timeout guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic result_t make_result(logic [swb_pkg::StatusWidth-1:0] st,
                                          logic [63:0] k, logic [63:0] v, logic l,
                                          int unsigned occ);
    result_t r;
    r.status = st;
    r.okey = k;
    r.oval = v;
    r.last = l;
    r.occ = occ[swb_pkg::OccWidth-1:0];
    return r;
  endfunction

  // Queues one expected result and remembers it for the directed checks.
  task automatic push_expected(input result_t r);
    pending_results.push_back(r);
    last_predicted = r;
    predicted_total++;
  endtask

  // Computes the results of one transfer and updates the shadow buffer.
  task automatic predict_buffer(input logic func, input logic [63:0] key,
                                input logic [63:0] value);
    int unsigned pos;
    pos = 0;
    if (func == swb_pkg::FuncInsert) begin
      while (pos < shadow_count && shadow_keys[pos] < key) pos++;
      if (pos < shadow_count && shadow_keys[pos] == key) begin
        shadow_values[pos] = value;
        push_expected(make_result(swb_pkg::StUpdated, '0, '0, 1'b1, shadow_count));
      end else if (shadow_count >= Depth) begin
        push_expected(make_result(swb_pkg::StDropped, '0, '0, 1'b1, shadow_count));
      end else begin
        for (int j = shadow_count; j > pos; j--) begin
          shadow_keys[j] = shadow_keys[j-1];
          shadow_values[j] = shadow_values[j-1];
        end
        shadow_keys[pos] = key;
        shadow_values[pos] = value;
        shadow_count++;
        push_expected(make_result(swb_pkg::StNew, '0, '0, 1'b1, shadow_count));
      end
    end else if (shadow_count == 0) begin
      push_expected(make_result(swb_pkg::StEmpty, '0, '0, 1'b1, 0));
    end else begin
      for (int i = 0; i < shadow_count; i++)
        push_expected(make_result(swb_pkg::StFlushed, shadow_keys[i], shadow_values[i],
                                  i + 1 == shadow_count, 0));
      shadow_count = 0;
    end
  endtask

  // Drives one item and waits for its transfer; valid drops only when a gap follows.
  task automatic send_item(input logic func, input logic [63:0] key,
                           input logic [63:0] value);
    int unsigned gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    func_i <= func;
    key_i <= key;
    value_i <= value;
    do @(posedge clk_i); while (!ready_o);
    predict_buffer(func, key, value);
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_off) ready_i <= 1'b0;
    else if ($urandom_range(0, 19) == 0) ready_i <= 1'b0;
    else if ($urandom_range(0, 3) == 0) ready_i <= $urandom_range(0, 1);
    else ready_i <= 1'b1;
  end

  // Result checker.
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && valid_o && ready_i) begin
      got = {status_o, out_key_o, out_value_o, last_o, occupancy_o};
      if (pending_results.size() == 0) begin
        report_mismatch("result with no expectation");
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status)
          report_mismatch($sformatf("status %0d exp %0d", got.status, want.status));
        if (got.okey != want.okey)
          report_mismatch($sformatf("key %h exp %h", got.okey, want.okey));
        if (got.oval != want.oval)
          report_mismatch($sformatf("value %h exp %h", got.oval, want.oval));
        if (got.last != want.last)
          report_mismatch($sformatf("last %0d exp %0d", got.last, want.last));
        if (got.occ != want.occ)
          report_mismatch($sformatf("occupancy %0d exp %0d", got.occ, want.occ));
      end
    end
  end

  function automatic stim_row_t make_row(logic func, logic [63:0] key, logic [63:0] value,
                                         bit has, result_t r);
    stim_row_t s;
    s.func = func;
    s.key = key;
    s.value = value;
    s.has_result = has;
    s.result = r;
    return s;
  endfunction

  task automatic build_directed_rows();
    result_t none;
    none = '0;
    // Empty flush after reset, then extreme keys and values.
    directed_rows.push_back(make_row(swb_pkg::FuncFlush, '0, '0, 1,
                                     make_result(swb_pkg::StEmpty, '0, '0, 1'b1, 0)));
    directed_rows.push_back(make_row(swb_pkg::FuncInsert, '1, '1, 1,
                                     make_result(swb_pkg::StNew, '0, '0, 1'b1, 1)));
    directed_rows.push_back(make_row(swb_pkg::FuncInsert, '0, '0, 1,
                                     make_result(swb_pkg::StNew, '0, '0, 1'b1, 2)));
    directed_rows.push_back(make_row(swb_pkg::FuncInsert, 64'h8000_0000_0000_0000,
                                     64'h5555_5555_5555_5555, 0, none));
    // Equal key overwrites, including key zero, then a new key and two flushes, the second one empty.
    directed_rows.push_back(make_row(swb_pkg::FuncInsert, '0, 64'hAAAA_AAAA_AAAA_AAAA, 1,
                                     make_result(swb_pkg::StUpdated, '0, '0, 1'b1, 3)));
    directed_rows.push_back(make_row(swb_pkg::FuncInsert, '1, 64'h1, 0, none));
    directed_rows.push_back(make_row(swb_pkg::FuncInsert, 64'h7FFF_FFFF_FFFF_FFFF, '1, 0,
                                     none));
    directed_rows.push_back(make_row(swb_pkg::FuncFlush, '1, '1, 0, none));
    directed_rows.push_back(make_row(swb_pkg::FuncFlush, '0, '0, 1,
                                     make_result(swb_pkg::StEmpty, '0, '0, 1'b1, 0)));
  endtask

  // Fills the buffer, hits the full-buffer cases, then flushes it.
  task automatic fill_and_overflow();
    for (int i = 0; i < Depth; i++)
      send_item(swb_pkg::FuncInsert, {$urandom, $urandom} | 64'h1, {$urandom, $urandom});
    send_item(swb_pkg::FuncInsert, '0, 64'h1234);
    send_item(swb_pkg::FuncInsert, shadow_keys[$urandom_range(0, shadow_count - 1)],
              {$urandom, $urandom});
    send_item(swb_pkg::FuncFlush, '0, '0);
  endtask

  initial begin
    int unsigned row_results;
    logic [63:0] key_pool[16];
    logic [63:0] k;
    int unsigned pick;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; typed expectations are checked against the predictor too.
    build_directed_rows();
    foreach (directed_rows[r]) begin
      row_results = predicted_total;
      send_item(directed_rows[r].func, directed_rows[r].key, directed_rows[r].value);
      if (directed_rows[r].has_result &&
          (predicted_total != row_results + 1 || last_predicted != directed_rows[r].result))
        report_mismatch($sformatf("directed row %0d disagrees with predictor", r));
    end

    // Full buffer, while the receiver holds off so the block backs up.
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      fill_and_overflow();
    join

    // Random traffic over a small key pool so updates are common.
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int n = 0; n < NumRandom; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_item(swb_pkg::FuncFlush, {$urandom, $urandom}, {$urandom, $urandom});
      end else begin
        k = (pick < 60) ? key_pool[$urandom_range(0, 15)] : {$urandom, $urandom};
        send_item(swb_pkg::FuncInsert, k, {$urandom, $urandom});
      end
    end
    send_item(swb_pkg::FuncFlush, '0, '0);
    valid_i <= 1'b0;

    // Drain, then let the pipeline settle.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
